// ===== rtl/core/frm_pkg.sv =====
`default_nettype none

package frm_pkg;

   // frame constants
   localparam logic [7:0] PRE_FIRST   = 8'h55;
   localparam logic [7:0] PRE_SECOND  = 8'hAA;
   localparam logic [8:0] MIN_FRAME   = 9'd5;
   localparam logic [19:0] ELAPSED_MAX = 20'hFFFFF;

   // configuration port shape
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MASTER_MODE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_FRAME_BYTES = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICK_STEP_US    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_US      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LOST        = 3'd4;

   // item modes
   localparam logic [2:0] MODE_RX_BYTE   = 3'd0;
   localparam logic [2:0] MODE_TICK      = 3'd1;
   localparam logic [2:0] MODE_LINE_ERR  = 3'd2;
   localparam logic [2:0] MODE_SEND_DONE = 3'd3;
   localparam logic [2:0] MODE_ENABLE    = 3'd4;
   localparam logic [2:0] MODE_DISABLE   = 3'd5;

   typedef enum logic [1:0] {
      ST_DISABLED = 2'd0,
      ST_IDLE     = 2'd1,
      ST_WAIT     = 2'd2,
      ST_ERROR    = 2'd3
   } rx_state_type;

   typedef struct packed {
      logic        master_mode;
      logic [8:0]  max_frame_bytes;
      logic [15:0] tick_step_us;
      logic [19:0] timeout_us;
      logic [7:0]  max_lost;
   } cfg_type;

   typedef struct packed {
      logic        byte_accepted;
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic [7:0]  payload_index;
      logic        frame_done;
      logic        checksum_ok;
      logic [7:0]  command;
      logic [7:0]  payload_length;
      logic        timeout_hit;
      logic        link_up;
      logic [1:0]  receiver_state;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/core/frm_if.sv =====
`default_nettype none

// input item channel
interface frm_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic [7:0] rx_byte;

   modport source (output valid, output mode, output rx_byte, input ready);
   modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

// result item channel
interface frm_rsp_if;
   logic       valid;
   logic       ready;
   logic       byte_accepted;
   logic       payload_valid;
   logic [7:0] payload_byte;
   logic [7:0] payload_index;
   logic       frame_done;
   logic       checksum_ok;
   logic [7:0] command;
   logic [7:0] payload_length;
   logic       timeout_hit;
   logic       link_up;
   logic [1:0] receiver_state;

   modport source (output valid, output byte_accepted, output payload_valid,
                   output payload_byte, output payload_index, output frame_done,
                   output checksum_ok, output command, output payload_length,
                   output timeout_hit, output link_up, output receiver_state,
                   input ready);
   modport sink   (input valid, input byte_accepted, input payload_valid,
                   input payload_byte, input payload_index, input frame_done,
                   input checksum_ok, input command, input payload_length,
                   input timeout_hit, input link_up, input receiver_state,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/core/frm_csr.sv =====
`default_nettype none

module frm_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [frm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [frm_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output frm_pkg::cfg_type                      cfg
);

   frm_pkg::cfg_type cfg_ff;

   // register writes, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.master_mode     <= 1'b1;
         cfg_ff.max_frame_bytes <= 9'd260;
         cfg_ff.tick_step_us    <= 16'd1000;
         cfg_ff.timeout_us      <= 20'd100000;
         cfg_ff.max_lost        <= 8'd10;
      end else if (csr_we) begin
         case (csr_index)
            frm_pkg::CSR_MASTER_MODE:     cfg_ff.master_mode     <= csr_wdata[0];
            frm_pkg::CSR_MAX_FRAME_BYTES: cfg_ff.max_frame_bytes <= csr_wdata[8:0];
            frm_pkg::CSR_TICK_STEP_US:    cfg_ff.tick_step_us    <= csr_wdata[15:0];
            frm_pkg::CSR_TIMEOUT_US:      cfg_ff.timeout_us      <= csr_wdata[19:0];
            frm_pkg::CSR_MAX_LOST:        cfg_ff.max_lost        <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/core/frm_core.sv =====
`default_nettype none

module frm_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire logic [2:0]  mode,
   input  wire logic [7:0]  rx_byte,
   input  wire frm_pkg::cfg_type cfg,
   output frm_pkg::result_type result
);

   frm_pkg::rx_state_type state_ff, state_in, state_dflt;
   logic [8:0]  pos_ff, pos_in, pos_v;
   logic [8:0]  len_ff, len_in;
   logic [7:0]  sum_ff, sum_in, sum_v;
   logic [7:0]  cmd_ff, cmd_in;
   logic [7:0]  plen_ff, plen_in;
   logic [19:0] elapsed_ff, elapsed_in, elapsed_v;
   logic [20:0] elapsed_add;
   logic [7:0]  lost_ff, lost_in, lost_inc;
   logic [8:0]  need_len;
   frm_pkg::result_type res;

   assign state_dflt  = cfg.master_mode ? frm_pkg::ST_IDLE : frm_pkg::ST_WAIT;
   assign lost_inc    = (lost_ff < cfg.max_lost) ? lost_ff + 8'd1 : lost_ff;
   assign need_len    = frm_pkg::MIN_FRAME + {1'b0, rx_byte};
   assign elapsed_add = {1'b0, elapsed_ff} + {5'd0, cfg.tick_step_us};

   // per item state update and result
   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      len_in     = len_ff;
      sum_in     = sum_ff;
      cmd_in     = cmd_ff;
      plen_in    = plen_ff;
      elapsed_in = elapsed_ff;
      lost_in    = lost_ff;
      pos_v      = pos_ff;
      sum_v      = sum_ff;
      elapsed_v  = elapsed_ff;
      res        = '0;
      case (mode)
         frm_pkg::MODE_RX_BYTE: begin
            if (state_ff == frm_pkg::ST_WAIT) begin
               if (pos_ff == 9'd0) begin
                  pos_v = (rx_byte == frm_pkg::PRE_FIRST) ? 9'd1 : 9'd0;
               end else if (pos_ff == 9'd1) begin
                  pos_v  = (rx_byte == frm_pkg::PRE_SECOND) ? 9'd2 : 9'd0;
                  len_in = frm_pkg::MIN_FRAME;
               end else if (pos_ff == 9'd3) begin
                  plen_in = rx_byte;
                  if (cfg.max_frame_bytes >= need_len) begin
                     len_in = len_ff + {1'b0, rx_byte};
                     sum_in = sum_ff + rx_byte;
                     pos_v  = 9'd4;
                  end else begin
                     pos_v = 9'd0;
                  end
               end else begin
                  // command byte seeds the sum
                  if (pos_ff == 9'd2) begin
                     cmd_in = rx_byte;
                     sum_v  = rx_byte;
                     sum_in = rx_byte;
                  end
                  pos_v = pos_ff + 9'd1;
                  if (pos_v >= len_ff) begin
                     res.frame_done  = 1'b1;
                     res.checksum_ok = (rx_byte == sum_v);
                     lost_in  = (rx_byte == sum_v) ? 8'd0 : lost_inc;
                     state_in = frm_pkg::ST_IDLE;
                  end else if (pos_ff >= 9'd4) begin
                     res.payload_valid = 1'b1;
                     res.payload_byte  = rx_byte;
                     res.payload_index = pos_ff[7:0] - 8'd4;
                     sum_in = sum_v + rx_byte;
                  end
               end
               elapsed_in        = '0;
               pos_in            = pos_v;
               res.byte_accepted = (pos_v != 9'd0);
            end else if (state_ff == frm_pkg::ST_ERROR) begin
               elapsed_in = '0;
            end
         end
         frm_pkg::MODE_TICK: begin
            if (state_ff != frm_pkg::ST_DISABLED) begin
               // saturating elapsed time, then timeout check
               if (elapsed_ff < cfg.timeout_us) begin
                  elapsed_v = elapsed_add[20] ? frm_pkg::ELAPSED_MAX : elapsed_add[19:0];
               end
               elapsed_in = elapsed_v;
               if (elapsed_v >= cfg.timeout_us) begin
                  state_in        = state_dflt;
                  pos_in          = '0;
                  len_in          = '0;
                  lost_in         = lost_inc;
                  res.timeout_hit = 1'b1;
               end
            end
         end
         frm_pkg::MODE_LINE_ERR: begin
            if (state_ff == frm_pkg::ST_WAIT) begin
               state_in   = frm_pkg::ST_ERROR;
               elapsed_in = '0;
            end
         end
         frm_pkg::MODE_SEND_DONE: begin
            if (state_ff == frm_pkg::ST_IDLE) begin
               state_in   = frm_pkg::ST_WAIT;
               pos_in     = '0;
               len_in     = '0;
               elapsed_in = '0;
            end else if (state_ff != frm_pkg::ST_DISABLED) begin
               state_in = state_dflt;
               pos_in   = '0;
               len_in   = '0;
            end
         end
         frm_pkg::MODE_ENABLE: begin
            state_in   = state_dflt;
            pos_in     = '0;
            len_in     = '0;
            elapsed_in = '0;
         end
         frm_pkg::MODE_DISABLE: begin
            state_in = frm_pkg::ST_DISABLED;
            lost_in  = cfg.max_lost;
         end
         default: ;
      endcase
      res.command        = cmd_in;
      res.payload_length = plen_in;
      res.link_up        = (state_in != frm_pkg::ST_DISABLED) && (lost_in < cfg.max_lost);
      res.receiver_state = state_in;
   end

   // receiver state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= frm_pkg::ST_DISABLED;
         pos_ff     <= '0;
         len_ff     <= '0;
         sum_ff     <= '0;
         cmd_ff     <= '0;
         plen_ff    <= '0;
         elapsed_ff <= '0;
         lost_ff    <= 8'd10;
      end else if (step) begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         len_ff     <= len_in;
         sum_ff     <= sum_in;
         cmd_ff     <= cmd_in;
         plen_ff    <= plen_in;
         elapsed_ff <= elapsed_in;
         lost_ff    <= lost_in;
      end
   end

   assign result = res;

endmodule

`default_nettype wire

// ===== rtl/core/serial_frame_receiver_sum_check_unit.sv =====
`default_nettype none

// channel   dir  handshake     payload
// req       in   valid/ready   mode, rx_byte
// rsp       out  valid/ready   byte_accepted .. receiver_state
// csr       in   csr_we        csr_index, csr_wdata
//
// one item per cycle sustained while rsp is ready; rsp valid follows req accept
// through the input register, then receiver update into the result register
// synchronous active-high reset; receiver comes up disabled
// req stays ready while a result waits, as long as the input register can drain
// a stalled rsp holds its result and at most one more item sits in the input register

module serial_frame_receiver_sum_check_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   frm_req_if.sink                              req,
   frm_rsp_if.source                            rsp,
   input  wire logic                            csr_we,
   input  wire logic [frm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [frm_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic                in_valid_ff;
   logic [2:0]          in_mode_ff;
   logic [7:0]          in_byte_ff;
   logic                out_valid_ff;
   frm_pkg::result_type out_ff;
   frm_pkg::result_type result;
   frm_pkg::cfg_type    cfg;
   logic                advance;
   logic                take;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign take      = req.valid && req.ready;

   frm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   frm_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .mode    (in_mode_ff),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_mode_ff <= req.mode;
         in_byte_ff <= req.rx_byte;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.byte_accepted  = out_ff.byte_accepted;
   assign rsp.payload_valid  = out_ff.payload_valid;
   assign rsp.payload_byte   = out_ff.payload_byte;
   assign rsp.payload_index  = out_ff.payload_index;
   assign rsp.frame_done     = out_ff.frame_done;
   assign rsp.checksum_ok    = out_ff.checksum_ok;
   assign rsp.command        = out_ff.command;
   assign rsp.payload_length = out_ff.payload_length;
   assign rsp.timeout_hit    = out_ff.timeout_hit;
   assign rsp.link_up        = out_ff.link_up;
   assign rsp.receiver_state = out_ff.receiver_state;

`ifndef ASSERT_OFF
   // an item leaving the input register always lands in the result register
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced item did not reach result register");

   // link is never reported up while disabled
   a_link_disabled: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_ff.link_up &&
                         out_ff.receiver_state == frm_pkg::ST_DISABLED))
      else $error("link up while receiver disabled");

   // the checksum byte is never also a payload byte
   a_done_not_payload: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_ff.frame_done && out_ff.payload_valid))
      else $error("frame end flagged on a payload byte");

   // an empty input register never blocks the request side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req.ready)
      else $error("request stalled with empty input register");
`endif

endmodule

`default_nettype wire
